/* rtl/decimal_bignum_scalar_multiply_assert.svh */
// Assertion macros for the decimal big-integer multiplier.
// Included by dbsm_datapath, which checks its own logic; no other dependency.
`ifndef DECIMAL_BIGNUM_SCALAR_MULTIPLY_ASSERT_SVH
`define DECIMAL_BIGNUM_SCALAR_MULTIPLY_ASSERT_SVH
`ifndef SYNTH
`define DBSM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define DBSM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DBSM_ASSERT_IMP(label, clk, rst, ante, cons)
`define DBSM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/dbsm_pkg.sv */
// Shared types and constants for the decimal big-integer multiplier.
// No dependencies; used by the controller, the datapath and the top level.
package dbsm_pkg;

  localparam int DIGITS_DEFAULT = 1024;

  localparam int KIND_W   = 2;
  localparam int FACTOR_W = 16;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int VALUE_W  = 4;
  localparam int CARRY_W  = 16;
  localparam int SUM_W    = 17;
  localparam int QUOT_W   = 13;
  localparam int PROD_W   = 33;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MUL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every x below 81920
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic capture;
    logic start;
    logic setup;
    logic step;
    logic tail_step;
    logic set_ovf;
    logic rd_en;
    logic rd_req;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic last_digit;
    logic carry_zero;
    logic len_full;
  } dp_status_t;

endpackage

/* rtl/dbsm_ctrl.sv */
// Sequencer for the decimal big-integer multiplier: walks start, multiply
// and read items through the datapath. Depends on dbsm_pkg.
module dbsm_ctrl
  import dbsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  output logic              out_valid,
  input  logic              out_ready,
  input  dp_status_t        st,
  output dp_cmd_t           cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SETUP,
    S_DIGIT,
    S_TAIL,
    S_READ,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          priority if (kind == KIND_START) state_next = S_START;
          else if (kind == KIND_MUL) state_next = S_SETUP;
          else if (kind == KIND_READ) state_next = S_READ;
          else state_next = S_DONE;
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_DONE;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        cmd.rd_en  = 1'b1;
        state_next = st.len_zero ? S_DONE : S_DIGIT;
      end
      S_DIGIT: begin
        cmd.step  = 1'b1;
        cmd.rd_en = 1'b1;
        if (st.last_digit) state_next = S_TAIL;
      end
      S_TAIL: begin
        priority if (st.carry_zero) begin
          state_next = S_DONE;
        end else if (st.len_full) begin
          cmd.set_ovf = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.tail_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_req = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/dbsm_datapath.sv */
// Digit store, carry chain and result register of the decimal big-integer
// multiplier. Depends on dbsm_pkg and the assertion macro header.
`include "decimal_bignum_scalar_multiply_assert.svh"
module dbsm_datapath
  import dbsm_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_status_t          st,
  input  logic [KIND_W-1:0]   kind,
  input  logic [FACTOR_W-1:0] factor,
  input  logic [INDEX_W-1:0]  digit_index,
  output logic [COUNT_W-1:0]  digit_count,
  output logic [VALUE_W-1:0]  digit_value,
  output logic                overflowed
);

  localparam int IW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CW    = $clog2(DIGITS + 1);
  localparam int EXT_W = IW + INDEX_W;

  logic [VALUE_W-1:0]  mem [DIGITS];
  logic [VALUE_W-1:0]  rdata;

  logic [KIND_W-1:0]   req_kind;
  logic [FACTOR_W-1:0] req_factor;
  logic [INDEX_W-1:0]  req_index;
  logic [CW-1:0]       len;
  logic                ovf;
  logic [CW-1:0]       ptr;
  logic [CARRY_W-1:0]  carry;
  logic [QUOT_W-1:0]   fq;
  logic [VALUE_W-1:0]  fr;

  logic [CW-1:0]       ptr_next;
  logic [EXT_W-1:0]    idx_ext;
  logic [IW-1:0]       raddr;
  logic [IW-1:0]       waddr;
  logic [VALUE_W-1:0]  wdata;
  logic                we;
  logic                in_range;

  logic [PROD_W-1:0]   fprod;
  logic [QUOT_W-1:0]   fq_calc;
  logic [FACTOR_W-1:0] f10;
  logic [FACTOR_W-1:0] fr_wide;

  logic [VALUE_W-1:0]  digit_in;
  logic [7:0]          dfr;
  logic [SUM_W-1:0]    s;
  logic [PROD_W-1:0]   sprod;
  logic [QUOT_W-1:0]   q;
  logic [SUM_W-1:0]    q10;
  logic [SUM_W-1:0]    rem;
  logic [SUM_W-1:0]    dfq;
  logic [SUM_W-1:0]    cn;

  // factor split into tens and units, done once per multiply
  assign fprod   = PROD_W'(req_factor) * PROD_W'(RECIP_10);
  assign fq_calc = fprod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  assign f10     = FACTOR_W'({fq_calc, 3'b000}) + FACTOR_W'({fq_calc, 1'b0});
  assign fr_wide = req_factor - f10;

  // digit * factor + carry == 10 * (digit * fq + s / 10) + s % 10
  assign digit_in = cmd.tail_step ? '0 : rdata;
  assign dfr      = 8'(digit_in) * 8'(fr);
  assign s        = SUM_W'(dfr) + SUM_W'(carry);
  assign sprod    = PROD_W'(s) * PROD_W'(RECIP_10);
  assign q        = sprod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  assign q10      = SUM_W'({q, 3'b000}) + SUM_W'({q, 1'b0});
  assign rem      = s - q10;
  assign dfq      = SUM_W'(digit_in) * SUM_W'(fq);
  assign cn       = dfq + SUM_W'(q);

  assign ptr_next = cmd.setup ? '0 : ptr + CW'(1);
  assign idx_ext  = EXT_W'(req_index);
  assign raddr    = cmd.rd_req ? idx_ext[IW-1:0] : ptr_next[IW-1:0];
  assign in_range = 32'(req_index) < 32'(len);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (cmd.start) begin
      we    = 1'b1;
      wdata = VALUE_W'(1);
    end else if (cmd.step) begin
      we    = 1'b1;
      waddr = ptr[IW-1:0];
      wdata = rem[VALUE_W-1:0];
    end else if (cmd.tail_step) begin
      we    = 1'b1;
      waddr = len[IW-1:0];
      wdata = rem[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.start) len <= CW'(1);
      else if (cmd.tail_step) len <= len + CW'(1);
      if (cmd.set_ovf) ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind   <= kind;
      req_factor <= factor;
      req_index  <= digit_index;
    end
    if (cmd.setup) begin
      fq    <= fq_calc;
      fr    <= fr_wide[VALUE_W-1:0];
      carry <= '0;
    end else if (cmd.step || cmd.tail_step) begin
      carry <= cn[CARRY_W-1:0];
    end
    if (cmd.setup || cmd.step) ptr <= ptr_next;
    if (cmd.load_out) begin
      digit_count <= COUNT_W'(32'(len));
      overflowed  <= ovf;
      digit_value <= (req_kind == KIND_READ && in_range) ? rdata : '0;
    end
  end

  assign st.len_zero   = (len == '0);
  assign st.last_digit = (ptr + CW'(1) == len);
  assign st.carry_zero = (carry == '0);
  assign st.len_full   = (len == CW'(DIGITS));

  `DBSM_ASSERT_IMP(a_len_bound, clk, rst, 1'b1, len <= CW'(DIGITS))
  `DBSM_ASSERT_IMP(a_step_in_range, clk, rst, cmd.step, ptr < len)
  `DBSM_ASSERT_NXT(a_tail_grows, clk, rst, cmd.tail_step, len == $past(len) + CW'(1))
  `DBSM_ASSERT_NXT(a_ovf_sticky, clk, rst, ovf, ovf)

endmodule

/* rtl/decimal_bignum_scalar_multiply.sv */
// Decimal big-integer multiplier by a 16-bit factor.
// Input channel (in_valid/in_ready) carries kind, factor and digit_index;
// output channel (out_valid/out_ready) returns digit_count, digit_value and
// overflowed, exactly one transfer per input transfer, in order.
// Kinds: start sets the number to one, multiply scales it in place, read
// returns one digit (zero at or past the count).
// A multiply runs a setup step, then the carry chain over its N held
// digits, then appends T carry digits (at most 5); with no digit held it
// ends after setup. The carry chain reads one digit and writes one digit
// of the store per cycle.
// One item is in work at a time; in_ready is high only while idle.
// A finished result sits in the output register until taken; while the
// receiver stalls, the block holds the next result and accepts no item
// beyond it.
// Reset clears the digit count and the overflow flag; the digit store needs
// no clearing pass, as only digits below the count are used.
// Depends on dbsm_pkg, dbsm_ctrl and dbsm_datapath.
module decimal_bignum_scalar_multiply
  import dbsm_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [FACTOR_W-1:0] factor,
  input  logic [INDEX_W-1:0]  digit_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COUNT_W-1:0]  digit_count,
  output logic [VALUE_W-1:0]  digit_value,
  output logic                overflowed
);

  dp_cmd_t    cmd;
  dp_status_t st;

  dbsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  dbsm_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .kind        (kind),
    .factor      (factor),
    .digit_index (digit_index),
    .digit_count (digit_count),
    .digit_value (digit_value),
    .overflowed  (overflowed)
  );

endmodule
